// ===== rtl/sws_pkg.sv =====
package sws_pkg;

  localparam int DEF_WINDOW_DEPTH = 64;
  localparam int DEF_SAMPLE_BITS  = 24;

  localparam int LEN_BITS   = 7;
  localparam int COUNT_BITS = 7;
  localparam int PADDR_BITS = 3;

  localparam logic [PADDR_BITS-1:0] ADDR_WINDOW_LENGTH = 3'd0;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS1,
    ST_DIV_MEAN,
    ST_PASS2,
    ST_DIV_VAR,
    ST_SQRT,
    ST_DONE
  } sws_state_t;

endpackage

// ===== rtl/sliding_window_statistics_top.sv =====
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_stall     in_command, in_sample_us
// out      output     out_valid / out_stall   out_sample_count, out_min_us, out_max_us,
//                                             out_mean_us, out_stddev_us, out_stats_valid
// cfg      input      APB (cfg_psel ...)      window_length at byte address 0
//
// An add item makes two read passes over the sample memory, two bit-serial divisions
// and a bit-serial square root. One item is worked on at a time; the next is taken
// while a result waits in the output register. Reset is synchronous; the sample memory
// is not cleared.
module sliding_window_statistics_top import sws_pkg::*; #(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_command,
  input  logic [SAMPLE_BITS-1:0] in_sample_us,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COUNT_BITS-1:0]  out_sample_count,
  output logic [SAMPLE_BITS-1:0] out_min_us,
  output logic [SAMPLE_BITS-1:0] out_max_us,
  output logic [SAMPLE_BITS-1:0] out_mean_us,
  output logic [SAMPLE_BITS-1:0] out_stddev_us,
  output logic                   out_stats_valid,

  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [PADDR_BITS-1:0]  cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W;
  localparam int SQC_W  = $clog2(SAMPLE_BITS + 1);
  localparam int RESET_LEN = (WINDOW_DEPTH < 64) ? WINDOW_DEPTH : 64;

  // Sample memory.
  logic [SAMPLE_BITS-1:0] store_mem [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_r;

  sws_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  len_r;
  logic [ADDR_W-1:0] wp_r;
  logic [CNT_W-1:0]  fill_r;
  logic              cmd_r;

  logic [CNT_W-1:0]  idx_r;
  logic              rv_r;
  logic              d2v_r;
  logic [2*SAMPLE_BITS-1:0] d2_r;

  logic [SUM_W-1:0]       sum_r;
  logic [SQ_W-1:0]        sq_r;
  logic [SAMPLE_BITS-1:0] min_r, max_r, mean_r;

  logic [2*SAMPLE_BITS-1:0] xs_r;
  logic [SAMPLE_BITS:0]     srem_r;
  logic [SAMPLE_BITS-1:0]   root_r;
  logic [SQC_W-1:0]         sqc_r;

  logic [SAMPLE_BITS-1:0] held_min_r, held_max_r, held_mean_r, held_std_r;
  logic                   held_valid_r;
  logic                   out_valid_r;

  logic [COUNT_BITS-1:0]  out_cnt_r;
  logic [SAMPLE_BITS-1:0] out_min_r, out_max_r, out_mean_r, out_std_r;
  logic                   out_sv_r;

  logic in_acc, cfg_wr, issue, pass_end, sqrt_step, out_load, pass_clr;
  logic div_start, div_done;
  logic [SQ_W-1:0] div_dvd;
  logic [SQ_W-1:0] div_quo;

  logic [LEN_BITS-1:0] wlen;
  logic [CNT_W-1:0]    wlen_clamped;
  logic [CNT_W:0]      wp_use, wp_inc;
  logic [SAMPLE_BITS-1:0] dabs;
  logic [SAMPLE_BITS+2:0] srem_sh, strial, sdiff;
  logic                   sfits;

  assign in_acc  = in_valid && !in_stall;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                   && (cfg_paddr == ADDR_WINDOW_LENGTH);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_WINDOW_LENGTH) ? 32'(len_r) : 32'd0;

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_sample_count = out_cnt_r;
  assign out_min_us = out_min_r;
  assign out_max_us = out_max_r;
  assign out_mean_us = out_mean_r;
  assign out_stddev_us = out_std_r;
  assign out_stats_valid = out_sv_r;

  // Length written over the port: zero means one, too large saturates.
  assign wlen = cfg_pwdata[LEN_BITS-1:0];
  always_comb begin
    if (wlen == '0) begin
      wlen_clamped = CNT_W'(1);
    end else if (32'(wlen) > 32'(WINDOW_DEPTH)) begin
      wlen_clamped = CNT_W'(WINDOW_DEPTH);
    end else begin
      wlen_clamped = CNT_W'(wlen);
    end
  end

  always_comb begin
    wp_use = ({1'b0, CNT_W'(wp_r)} >= {1'b0, len_r}) ? '0 : {1'b0, CNT_W'(wp_r)};
    wp_inc = wp_use + 1'b1;
  end

  assign pass_end = (idx_r == fill_r) && !rv_r && !d2v_r;
  assign dabs = (rd_data_r >= mean_r) ? (rd_data_r - mean_r) : (mean_r - rd_data_r);

  assign srem_sh = {srem_r, xs_r[2*SAMPLE_BITS-1 -: 2]};
  assign strial  = {1'b0, root_r, 2'b01};
  assign sfits   = srem_sh >= strial;
  assign sdiff   = srem_sh - strial;

  assign div_dvd = (state_r == ST_PASS1) ? SQ_W'(sum_r) : sq_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_command == CMD_CLEAR) ? ST_DONE : ST_PASS1;
        end
      end
      ST_PASS1: begin
        if (pass_end) state_nxt = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: begin
        if (div_done) state_nxt = ST_PASS2;
      end
      ST_PASS2: begin
        if (pass_end) state_nxt = ST_DIV_VAR;
      end
      ST_DIV_VAR: begin
        if (div_done) state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (sqc_r == '0) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    issue = 1'b0;
    div_start = 1'b0;
    sqrt_step = 1'b0;
    out_load = 1'b0;
    pass_clr = 1'b0;
    case (state_r)
      ST_IDLE: pass_clr = 1'b1;
      ST_PASS1: begin
        issue = (idx_r != fill_r);
        div_start = pass_end;
      end
      ST_DIV_MEAN: pass_clr = 1'b1;
      ST_PASS2: begin
        issue = (idx_r != fill_r);
        div_start = pass_end;
      end
      ST_DIV_VAR: ;
      ST_SQRT: sqrt_step = (sqc_r != '0);
      ST_DONE: out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  sws_div #(.DVD_W(SQ_W), .DVS_W(CNT_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (fill_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (in_acc && (in_command == CMD_ADD)) begin
      store_mem[wp_use[ADDR_W-1:0]] <= in_sample_us;
    end
    rd_data_r <= store_mem[idx_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r <= CNT_W'(RESET_LEN);
      wp_r <= '0;
      fill_r <= '0;
      held_valid_r <= 1'b0;
      held_min_r <= '0;
      held_max_r <= '0;
      held_mean_r <= '0;
      held_std_r <= '0;
      out_valid_r <= 1'b0;
      idx_r <= '0;
      rv_r <= 1'b0;
      d2v_r <= 1'b0;
      sqc_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        len_r <= wlen_clamped;
        wp_r <= '0;
        fill_r <= '0;
      end else if (in_acc) begin
        if (in_command == CMD_CLEAR) begin
          wp_r <= '0;
          fill_r <= '0;
        end else begin
          wp_r <= (wp_inc >= {1'b0, len_r}) ? '0 : wp_inc[ADDR_W-1:0];
          if (fill_r < len_r) fill_r <= fill_r + 1'b1;
          else fill_r <= len_r;
        end
      end

      if (pass_clr) idx_r <= '0;
      else if (issue) idx_r <= idx_r + 1'b1;
      rv_r <= issue;
      d2v_r <= rv_r && (state_r == ST_PASS2);

      if (div_done && (state_r == ST_DIV_VAR)) sqc_r <= SQC_W'(SAMPLE_BITS);
      else if (sqrt_step) sqc_r <= sqc_r - 1'b1;

      if (out_load) begin
        out_valid_r <= 1'b1;
        if (cmd_r == CMD_ADD) begin
          held_min_r <= min_r;
          held_max_r <= max_r;
          held_mean_r <= mean_r;
          held_std_r <= root_r;
          held_valid_r <= 1'b1;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_command;
      sum_r <= '0;
      sq_r <= '0;
      min_r <= '1;
      max_r <= '0;
    end
    if (rv_r && (state_r == ST_PASS1)) begin
      sum_r <= sum_r + SUM_W'(rd_data_r);
      if (rd_data_r < min_r) min_r <= rd_data_r;
      if (rd_data_r > max_r) max_r <= rd_data_r;
    end
    d2_r <= dabs * dabs;
    if (d2v_r) sq_r <= sq_r + SQ_W'(d2_r);
    if (div_done && (state_r == ST_DIV_MEAN)) mean_r <= div_quo[SAMPLE_BITS-1:0];
    if (div_done && (state_r == ST_DIV_VAR)) begin
      // The mean squared deviation is below 2^(2*SAMPLE_BITS).
      xs_r <= div_quo[2*SAMPLE_BITS-1:0];
      srem_r <= '0;
      root_r <= '0;
    end else if (sqrt_step) begin
      xs_r <= {xs_r[2*SAMPLE_BITS-3:0], 2'b00};
      srem_r <= sfits ? sdiff[SAMPLE_BITS:0] : srem_sh[SAMPLE_BITS:0];
      root_r <= {root_r[SAMPLE_BITS-2:0], sfits};
    end
    if (out_load) begin
      out_cnt_r <= COUNT_BITS'(fill_r);
      if (cmd_r == CMD_ADD) begin
        out_min_r <= min_r;
        out_max_r <= max_r;
        out_mean_r <= mean_r;
        out_std_r <= root_r;
        out_sv_r <= 1'b1;
      end else begin
        out_min_r <= held_min_r;
        out_max_r <= held_max_r;
        out_mean_r <= held_mean_r;
        out_std_r <= held_std_r;
        out_sv_r <= held_valid_r;
      end
    end
  end

endmodule

// ===== rtl/sws_div.sv =====
module sws_div import sws_pkg::*; #(
  parameter int DVD_W = 55,
  parameter int DVS_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W:0]   rem_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   rem_sh;
  logic             fits;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_r[DVS_W-1:0], quo_r[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};
  assign done   = busy_r && (cnt_r == '0);
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DVD_W);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r && (cnt_r != '0)) begin
      rem_r <= fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

endmodule

// ===== dv/sliding_window_statistics_checker.sv =====
`timescale 1ns / 100ps
module sliding_window_statistics_checker import sws_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_command,
  input  logic [23:0]           in_sample_us,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [COUNT_BITS-1:0] out_sample_count,
  input  logic [23:0]           out_min_us,
  input  logic [23:0]           out_max_us,
  input  logic [23:0]           out_mean_us,
  input  logic [23:0]           out_stddev_us,
  input  logic                  out_stats_valid,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [PADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output int                    fail_count,
  output int                    pending_stats
);

  typedef struct packed {
    logic [6:0]  count;
    logic [23:0] min_us;
    logic [23:0] max_us;
    logic [23:0] mean_us;
    logic [23:0] stddev_us;
    logic        valid;
  } window_stats_t;

  window_stats_t stats_queue[$];
  logic [23:0]   ring[64];
  int unsigned   wr_ptr, fill, win_len;
  window_stats_t held;

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= x) r |= 64'd1 << b;
    return r;
  endfunction

  task automatic predict_item(logic cmd, logic [23:0] s);
    longint unsigned sum, mean, q, d;
    window_stats_t e;
    if (cmd == CMD_CLEAR) begin
      wr_ptr = 0;
      fill = 0;
    end else begin
      if (wr_ptr >= win_len) wr_ptr = 0;
      ring[wr_ptr] = s;
      wr_ptr = (wr_ptr + 1 >= win_len) ? 0 : wr_ptr + 1;
      if (fill < win_len) fill++;
      sum = 0;
      held.min_us = 24'hFFFFFF;
      held.max_us = 0;
      for (int i = 0; i < fill; i++) begin
        sum += ring[i];
        if (ring[i] < held.min_us) held.min_us = ring[i];
        if (ring[i] > held.max_us) held.max_us = ring[i];
      end
      mean = sum / fill;
      q = 0;
      // Exact sum of squares fits in 64 bits for 64 samples of 24 bits.
      for (int i = 0; i < fill; i++) begin
        d = (ring[i] >= mean) ? ring[i] - mean : mean - ring[i];
        q += d * d;
      end
      held.mean_us = mean[23:0];
      held.stddev_us = 24'(isqrt(q / fill));
      held.valid = 1'b1;
    end
    e = held;
    e.count = fill[6:0];
    stats_queue.push_back(e);
  endtask

  assign pending_stats = stats_queue.size();

  always @(posedge clk) begin
    window_stats_t e;
    if (!rst_n) begin
      stats_queue.delete();
      wr_ptr = 0;
      fill = 0;
      win_len = 64;
      held = '0;
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == ADDR_WINDOW_LENGTH) begin
        win_len = cfg_pwdata[6:0];
        if (win_len == 0) win_len = 1;
        if (win_len > 64) win_len = 64;
        wr_ptr = 0;
        fill = 0;
      end
      if (in_valid && !in_stall) predict_item(in_command, in_sample_us);
      if (out_valid && !out_stall) begin
        if (stats_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result at %0t", $realtime);
        end else begin
          e = stats_queue.pop_front();
          if (e != {out_sample_count, out_min_us, out_max_us, out_mean_us,
                    out_stddev_us, out_stats_valid}) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp n=%0d min=%0d max=%0d mean=%0d sd=%0d v=%0d got n=%0d min=%0d max=%0d mean=%0d sd=%0d v=%0d",
                       e.count, e.min_us, e.max_us, e.mean_us, e.stddev_us, e.valid,
                       out_sample_count, out_min_us, out_max_us, out_mean_us,
                       out_stddev_us, out_stats_valid);
          end
        end
      end
    end
  end

endmodule

// ===== dv/sliding_window_statistics_top_test.sv =====
`timescale 1ns / 100ps
module sliding_window_statistics_top_test;
  import sws_pkg::*;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_command = 0, out_stall = 0;
  logic [23:0] in_sample_us = 0;
  logic in_stall, out_valid, out_stats_valid, cfg_pready;
  logic [COUNT_BITS-1:0] out_sample_count;
  logic [23:0] out_min_us, out_max_us, out_mean_us, out_stddev_us;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [PADDR_BITS-1:0] cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0, cfg_prdata;
  int fail_count, pending_stats;
  int cycles = 0;
  bit calm = 0;

  always #5 clk = ~clk;

  sliding_window_statistics_top u_dut (.*);
  sliding_window_statistics_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 36);
    if (cycles > 3000000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Valid stays high after an accepted item until the next one or an idle cycle.
  task automatic send_item(logic cmd, logic [23:0] s);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_command <= cmd;
    in_sample_us <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_length(logic [31:0] v);
    in_valid <= 0;
    while (pending_stats != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= ADDR_WINDOW_LENGTH; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic random_item();
    logic [23:0] s;
    case ($urandom_range(3))
      0: s = 24'($urandom);
      1: s = 24'($urandom_range(20000, 10000));
      2: s = ($urandom_range(1)) ? 24'hFFFFFF : 24'h0;
      default: s = 24'($urandom_range(255));
    endcase
    send_item(($urandom_range(99) < 4) ? CMD_CLEAR : CMD_ADD, s);
  endtask

  initial begin
    int unsigned lens[6] = '{1, 2, 5, 17, 64, 0};
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_item(CMD_CLEAR, 0);
    send_item(CMD_ADD, 24'hFFFFFF);
    send_item(CMD_ADD, 24'h000000);
    send_item(CMD_ADD, 24'hFFFFFF);
    send_item(CMD_ADD, 24'hA5A5A5);
    send_item(CMD_CLEAR, 24'h5A5A5A);
    send_item(CMD_ADD, 24'd16666);
    write_length(0);
    send_item(CMD_ADD, 24'd7);
    send_item(CMD_ADD, 24'd9);
    write_length(32'hFFFF_FF7F);
    for (int i = 0; i < 66; i++) send_item(CMD_ADD, 24'hFFFFFF - i);
    foreach (lens[k]) begin
      write_length(k == 5 ? 100 : lens[k]);
      calm = (k == 3);
      for (int i = 0; i < 330; i++) random_item();
    end
    calm = 0;
    in_valid <= 0;
    while (pending_stats != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
